### sv/fcml_pkg.sv
package fcml_pkg;

	// Request actions
	typedef enum logic [1:0] {
		ACT_FRAME     = 2'd0,
		ACT_RD_CNT    = 2'd1,
		ACT_RD_ENTRY  = 2'd2,
		ACT_NONE      = 2'd3
	} action_t;

	// Frame classes reported in the response
	typedef enum logic [2:0] {
		CLS_ARP     = 3'd0,
		CLS_TCP     = 3'd1,
		CLS_UDP     = 3'd2,
		CLS_ICMP    = 3'd3,
		CLS_OTHER   = 3'd4,
		CLS_UNKNOWN = 3'd5
	} frame_class_t;

	// Statistic counter indexes
	localparam int NUM_CNT     = 9;
	localparam int CNT_IP      = 0;
	localparam int CNT_ARP     = 1;
	localparam int CNT_UNKNOWN = 2;
	localparam int CNT_TCP     = 3;
	localparam int CNT_UDP     = 4;
	localparam int CNT_ICMP    = 5;
	localparam int CNT_OTHER   = 6;
	localparam int CNT_REDIR   = 7;
	localparam int CNT_UNREACH = 8;

	// Header codes
	localparam logic [15:0] ETYPE_ARP    = 16'h0806;
	localparam logic [15:0] ETYPE_IP     = 16'h0800;
	localparam logic [7:0]  PROTO_TCP    = 8'd6;
	localparam logic [7:0]  PROTO_UDP    = 8'd17;
	localparam logic [7:0]  PROTO_ICMP   = 8'd1;
	localparam logic [7:0]  ICMP_UNREACH = 8'd3;
	localparam logic [7:0]  ICMP_REDIR   = 8'd5;

	// Configuration register indexes
	localparam logic REG_ICMP_DETAIL = 1'b0;
	localparam logic REG_UNKNOWN_EN  = 1'b1;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_LEARN_DST,
		S_LEARN_SRC,
		S_DONE
	} state_t;

	// Search keys broadcast to every cell
	typedef struct packed {
		logic [47:0] dst;
		logic [47:0] src;
		logic [5:0]  ridx;
		logic        rd_en;
	} key_t;

	// Token and partial results handed from cell to cell
	typedef struct packed {
		logic        tok;
		logic        hit_d;
		logic        hit_s;
		logic [47:0] rd;
	} link_t;

endpackage

### sv/fcml_req_if.sv
interface fcml_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [47:0] dst_mac;
	logic [47:0] src_mac;
	logic [15:0] etype;
	logic [7:0]  ip_protocol;
	logic [7:0]  itype;
	logic [5:0]  read_index;

	modport source (output valid, action, dst_mac, src_mac, etype, ip_protocol,
		itype, read_index, input ready);
	modport sink (input valid, action, dst_mac, src_mac, etype, ip_protocol,
		itype, read_index, output ready);
endinterface

### sv/fcml_rsp_if.sv
interface fcml_rsp_if;
	logic        valid;
	logic        ready;
	logic        dst_is_new;
	logic        src_is_new;
	logic [2:0]  frame_class;
	logic        table_full;
	logic [47:0] read_data;
	logic [6:0]  address_count;

	modport source (output valid, dst_is_new, src_is_new, frame_class, table_full,
		read_data, address_count, input ready);
	modport sink (input valid, dst_is_new, src_is_new, frame_class, table_full,
		read_data, address_count, output ready);
endinterface

### sv/fcml_cell.sv
module fcml_cell #(
	parameter int Idx      = 0,
	parameter int IdxWidth = 6,
	parameter int CntWidth = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  fcml_pkg::key_t      key,
	input  logic [CntWidth-1:0] count,
	input  logic                wr_en,
	input  logic [IdxWidth-1:0] wr_idx,
	input  logic [47:0]         wr_data,
	input  fcml_pkg::link_t     link_in,
	output fcml_pkg::link_t     link_out
);

	logic [47:0]     entry_q;
	logic            valid;
	logic            rd_sel;
	fcml_pkg::link_t link_d;
	logic            tok_q;
	logic            hit_d_q;
	logic            hit_s_q;
	logic [47:0]     rd_q;

	// Store a learned address when this slot is addressed
	always_ff @(posedge clk) begin
		if (wr_en && (wr_idx == IdxWidth'(Idx))) begin
			entry_q <= wr_data;
		end
	end

	// Entries fill in order, so a slot below the count holds an address
	assign valid  = count > CntWidth'(Idx);
	assign rd_sel = key.rd_en && (32'(key.ridx) == 32'(Idx));

	// Merge this slot's match and read data into the passing token
	always_comb begin
		link_d       = link_in;
		link_d.hit_d = link_in.hit_d | (valid && (entry_q == key.dst));
		link_d.hit_s = link_in.hit_s | (valid && (entry_q == key.src));
		link_d.rd    = link_in.rd | (rd_sel ? entry_q : 48'd0);
	end

	// Hand the token to the next slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= 1'b0;
		end else begin
			tok_q <= link_d.tok;
		end
	end

	always_ff @(posedge clk) begin
		hit_d_q <= link_d.hit_d;
		hit_s_q <= link_d.hit_s;
		rd_q    <= link_d.rd;
	end

	assign link_out = '{tok: tok_q, hit_d: hit_d_q, hit_s: hit_s_q, rd: rd_q};

endmodule

### sv/frame_classifier_mac_learner_core.sv
// Frames and entry reads send a search token along the row of address slots; frames then
// learn new addresses. Counter reads and unused actions go straight to the response.
// One request is in work at a time; a new one is taken while a finished response still waits
// at the output register. Reset clears counters, learned count and configuration (ICMP
// detail on, unknown count off); address slots are not cleared and need no clearing pass.
module frame_classifier_mac_learner_core #(
	parameter int TABLE_ENTRIES = 64,
	parameter int COUNTER_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic        cfg_data,
	fcml_req_if.sink    req,
	fcml_rsp_if.source  rsp
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

	fcml_pkg::state_t state_q, state_d;

	logic                     icmp_detail_q;
	logic                     unknown_en_q;
	logic [COUNTER_WIDTH-1:0] cnt_q [fcml_pkg::NUM_CNT];
	logic [fcml_pkg::NUM_CNT-1:0] bump;
	logic [CNT_W-1:0]         count_q;

	fcml_pkg::action_t act_q;
	logic [47:0]       dst_q;
	logic [47:0]       src_q;
	logic [5:0]        ridx_q;
	logic [2:0]        cls_q;
	logic [2:0]        cls_d;
	logic              hit_d_q;
	logic              hit_s_q;
	logic              dnew_q;
	logic              snew_q;
	logic              full_q;
	logic              dst_stored_q;
	logic [47:0]       rd_q;
	logic [47:0]       cnt_rd;
	logic [63:0]       cnt_ext;

	logic              accept;
	logic              start;
	logic              start_q;
	logic              load_out;
	logic              room;
	logic              src_new;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_idx;
	logic [47:0]       wr_data;
	logic [31:0]       count_ext;

	fcml_pkg::key_t  key;
	fcml_pkg::link_t lnk [TABLE_ENTRIES+1];

	logic        out_valid_q;
	logic        out_dnew_q;
	logic        out_snew_q;
	logic [2:0]  out_cls_q;
	logic        out_full_q;
	logic [47:0] out_rd_q;
	logic [6:0]  out_count_q;

	assign accept  = req.valid && req.ready;
	assign room    = count_q < FULL_CNT;
	assign src_new = !hit_s_q && !(dst_stored_q && (src_q == dst_q));

	// Sequencer: next state, handshake and slot write
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		start     = 1'b0;
		load_out  = 1'b0;
		wr_en     = 1'b0;
		wr_data   = dst_q;
		unique case (state_q)
			fcml_pkg::S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.action == fcml_pkg::ACT_FRAME ||
						req.action == fcml_pkg::ACT_RD_ENTRY) begin
						start   = 1'b1;
						state_d = fcml_pkg::S_SEARCH;
					end else begin
						state_d = fcml_pkg::S_DONE;
					end
				end
			end
			fcml_pkg::S_SEARCH: begin
				if (lnk[TABLE_ENTRIES].tok) begin
					state_d = (act_q == fcml_pkg::ACT_FRAME) ? fcml_pkg::S_LEARN_DST
						: fcml_pkg::S_DONE;
				end
			end
			fcml_pkg::S_LEARN_DST: begin
				wr_en   = !hit_d_q && room;
				wr_data = dst_q;
				state_d = fcml_pkg::S_LEARN_SRC;
			end
			fcml_pkg::S_LEARN_SRC: begin
				wr_en   = src_new && room;
				wr_data = src_q;
				state_d = fcml_pkg::S_DONE;
			end
			fcml_pkg::S_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = fcml_pkg::S_IDLE;
				end
			end
			default: state_d = fcml_pkg::S_IDLE;
		endcase
	end

	assign wr_idx = count_q[IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcml_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Launch the search token once the request is held
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 1'b0;
		end else begin
			start_q <= start;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			icmp_detail_q <= 1'b1;
			unknown_en_q  <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == fcml_pkg::REG_ICMP_DETAIL) icmp_detail_q <= cfg_data;
			if (cfg_index == fcml_pkg::REG_UNKNOWN_EN)  unknown_en_q  <= cfg_data;
		end
	end

	// Classify the frame and pick the counters to bump
	always_comb begin
		bump  = '0;
		cls_d = fcml_pkg::CLS_UNKNOWN;
		priority if (req.etype == fcml_pkg::ETYPE_ARP) begin
			cls_d = fcml_pkg::CLS_ARP;
			bump[fcml_pkg::CNT_ARP] = 1'b1;
		end else if (req.etype == fcml_pkg::ETYPE_IP) begin
			bump[fcml_pkg::CNT_IP] = 1'b1;
			priority if (req.ip_protocol == fcml_pkg::PROTO_TCP) begin
				cls_d = fcml_pkg::CLS_TCP;
				bump[fcml_pkg::CNT_TCP] = 1'b1;
			end else if (req.ip_protocol == fcml_pkg::PROTO_UDP) begin
				cls_d = fcml_pkg::CLS_UDP;
				bump[fcml_pkg::CNT_UDP] = 1'b1;
			end else if (req.ip_protocol == fcml_pkg::PROTO_ICMP) begin
				cls_d = fcml_pkg::CLS_ICMP;
				bump[fcml_pkg::CNT_ICMP] = 1'b1;
				if (icmp_detail_q) begin
					bump[fcml_pkg::CNT_UNREACH] = req.itype == fcml_pkg::ICMP_UNREACH;
					bump[fcml_pkg::CNT_REDIR]   = req.itype == fcml_pkg::ICMP_REDIR;
				end
			end else begin
				cls_d = fcml_pkg::CLS_OTHER;
				bump[fcml_pkg::CNT_OTHER] = 1'b1;
			end
		end else begin
			bump[fcml_pkg::CNT_UNKNOWN] = unknown_en_q;
		end
	end

	// Bump statistic counters on frame requests
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < fcml_pkg::NUM_CNT; i++) cnt_q[i] <= '0;
		end else if (accept && req.action == fcml_pkg::ACT_FRAME) begin
			for (int i = 0; i < fcml_pkg::NUM_CNT; i++) begin
				if (bump[i]) cnt_q[i] <= cnt_q[i] + COUNTER_WIDTH'(1);
			end
		end
	end

	// Counter read, zero beyond the last counter
	always_comb begin
		cnt_ext = '0;
		if (req.read_index < 6'(fcml_pkg::NUM_CNT)) begin
			cnt_ext = 64'(cnt_q[req.read_index[3:0]]);
		end
		cnt_rd = cnt_ext[47:0];
	end

	// Learned address count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (wr_en) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	// Hold the request and collect the search and learn results
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q        <= fcml_pkg::action_t'(req.action);
			dst_q        <= req.dst_mac;
			src_q        <= req.src_mac;
			ridx_q       <= req.read_index;
			cls_q        <= (req.action == fcml_pkg::ACT_FRAME) ? cls_d : 3'd0;
			rd_q         <= (req.action == fcml_pkg::ACT_RD_CNT) ? cnt_rd : 48'd0;
			dnew_q       <= 1'b0;
			snew_q       <= 1'b0;
			full_q       <= 1'b0;
			dst_stored_q <= 1'b0;
		end
		if (state_q == fcml_pkg::S_SEARCH && lnk[TABLE_ENTRIES].tok) begin
			hit_d_q <= lnk[TABLE_ENTRIES].hit_d;
			hit_s_q <= lnk[TABLE_ENTRIES].hit_s;
			if (act_q == fcml_pkg::ACT_RD_ENTRY &&
				CMP_W'(ridx_q) < CMP_W'(count_q)) begin
				rd_q <= lnk[TABLE_ENTRIES].rd;
			end
		end
		if (state_q == fcml_pkg::S_LEARN_DST) begin
			dnew_q       <= !hit_d_q;
			dst_stored_q <= !hit_d_q && room;
			if (!hit_d_q && !room) full_q <= 1'b1;
		end
		if (state_q == fcml_pkg::S_LEARN_SRC) begin
			snew_q <= src_new;
			if (src_new && !room) full_q <= 1'b1;
		end
	end

	// Row of address slots
	assign key.dst   = dst_q;
	assign key.src   = src_q;
	assign key.ridx  = ridx_q;
	assign key.rd_en = act_q == fcml_pkg::ACT_RD_ENTRY;

	assign lnk[0].tok   = start_q;
	assign lnk[0].hit_d = 1'b0;
	assign lnk[0].hit_s = 1'b0;
	assign lnk[0].rd    = 48'd0;

	for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_slot
		fcml_cell #(
			.Idx      (g),
			.IdxWidth (IDX_W),
			.CntWidth (CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.key      (key),
			.count    (count_q),
			.wr_en    (wr_en),
			.wr_idx   (wr_idx),
			.wr_data  (wr_data),
			.link_in  (lnk[g]),
			.link_out (lnk[g+1])
		);
	end

	// Output register
	assign count_ext = 32'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_dnew_q  <= dnew_q;
			out_snew_q  <= snew_q;
			out_cls_q   <= cls_q;
			out_full_q  <= full_q;
			out_rd_q    <= rd_q;
			out_count_q <= count_ext[6:0];
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.dst_is_new    = out_dnew_q;
	assign rsp.src_is_new    = out_snew_q;
	assign rsp.frame_class   = out_cls_q;
	assign rsp.table_full    = out_full_q;
	assign rsp.read_data     = out_rd_q;
	assign rsp.address_count = out_count_q;

endmodule
